@@ hdl/longest_prefix_route_lookup_core_defines.svh @@
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_core_defines
// assertion macros for the route lookup core, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_CORE_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication
`define LPRL_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define LPRL_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ hdl/lprl_pkg.sv @@
// ----------------------------------------------------------------------------
// lprl_pkg
// shared constants and types of the longest prefix route lookup core
// ----------------------------------------------------------------------------
package lprl_pkg;

  localparam int ROUTE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(ROUTE_ENTRIES);
  localparam int CNT_W         = $clog2(ROUTE_ENTRIES + 1);

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [5:0]  MAX_LEN  = 6'd32;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NO_ROUTE  = 3'd4;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  length;
    logic [31:0] gateway;
    logic [7:0]  port;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hdl/lprl_ram.sv @@
// ----------------------------------------------------------------------------
// lprl_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module lprl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/longest_prefix_route_lookup_core.sv @@
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_core
// ipv4 route table with insert and longest prefix match lookup
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one transaction: in_func selects
//   insert (route prefix, length, next hop, port) or lookup (destination).
//   result channel (out_valid/out_ready) returns one transaction per input:
//   hit, next hop, port and status.
//   every transaction walks the whole table through one compare unit, one
//   ram read per cycle; the next transaction is accepted only after the
//   walk has finished and its result has been loaded.
//   in_ready is low while a transaction walks the table.
//   an insert writes the lowest free entry at the end of the walk.
//   a held result does not block the next acceptance; a walk that finishes
//   while the result register is still full waits until out_ready.
//   reset (rst_n low, synchronous) empties the table at once through its
//   valid flops; route storage itself is not cleared.
// ----------------------------------------------------------------------------
`include "longest_prefix_route_lookup_core_defines.svh"

module longest_prefix_route_lookup_core
  import lprl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_prefix_length,
  input  logic [31:0] in_next_hop,
  input  logic [7:0]  in_out_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [31:0] out_route_next_hop,
  output logic [7:0]  out_route_port,
  output logic [2:0]  out_status
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     chk_vld_r, chk_vld_nxt;
  logic                     chk_vbit_r, chk_vbit_nxt;
  logic [IDX_W-1:0]         chk_idx_r, chk_idx_nxt;
  logic [ROUTE_ENTRIES-1:0] valid_r, valid_nxt;

  logic                     func_r, func_nxt;
  logic [31:0]              addr_r, addr_nxt;
  logic [5:0]               len_r, len_nxt;
  logic [31:0]              nh_r, nh_nxt;
  logic [7:0]               port_r, port_nxt;

  logic                     dup_r, dup_nxt;
  logic                     free_found_r, free_found_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic                     best_found_r, best_found_nxt;
  logic [5:0]               best_len_r, best_len_nxt;
  logic [31:0]              best_nh_r, best_nh_nxt;
  logic [7:0]               best_port_r, best_port_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_hit_r, out_hit_nxt;
  logic [31:0]              out_nh_r, out_nh_nxt;
  logic [7:0]               out_port_r, out_port_nxt;
  logic [2:0]               out_status_r, out_status_nxt;

  logic                     in_acc;
  logic                     issue;
  logic [IDX_W-1:0]         rd_idx;
  logic                     ram_we;
  entry_t                   wr_entry;
  entry_t                   rd_entry;
  logic [ENTRY_W-1:0]       rd_data;
  logic [31:0]              e_mask;
  logic                     e_dup;
  logic                     e_match;
  logic                     finish_go;

  lprl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ROUTE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (wr_entry),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign issue    = (state_r == S_SCAN) && (cnt_r != CNT_W'(ROUTE_ENTRIES));
  assign rd_idx   = cnt_r[IDX_W-1:0];

  // shared compare unit
  assign e_mask  = ~(ALL_ONES >> rd_entry.length);
  assign e_dup   = chk_vbit_r && (rd_entry.prefix == addr_r) && (rd_entry.length == len_r);
  assign e_match = chk_vbit_r && ((addr_r & e_mask) == rd_entry.prefix);

  assign finish_go = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign ram_we    = finish_go && (func_r == FUNC_INSERT) && !dup_r && free_found_r;

  always_comb begin
    wr_entry.prefix  = addr_r;
    wr_entry.length  = len_r;
    wr_entry.gateway = nh_r;
    wr_entry.port    = port_r;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_vbit_nxt   = chk_vbit_r;
    chk_idx_nxt    = chk_idx_r;
    valid_nxt      = valid_r;
    func_nxt       = func_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    nh_nxt         = nh_r;
    port_nxt       = port_r;
    dup_nxt        = dup_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    best_found_nxt = best_found_r;
    best_len_nxt   = best_len_r;
    best_nh_nxt    = best_nh_r;
    best_port_nxt  = best_port_r;
    out_valid_nxt  = out_valid_r;
    out_hit_nxt    = out_hit_r;
    out_nh_nxt     = out_nh_r;
    out_port_nxt   = out_port_r;
    out_status_nxt = out_status_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt       = in_func;
          addr_nxt       = in_address;
          len_nxt        = (in_prefix_length > MAX_LEN) ? MAX_LEN : in_prefix_length;
          nh_nxt         = in_next_hop;
          port_nxt       = in_out_port;
          dup_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          best_found_nxt = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          chk_vld_nxt  = 1'b1;
          chk_vbit_nxt = valid_r[rd_idx];
          chk_idx_nxt  = rd_idx;
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else if (!chk_vld_r) begin
          state_nxt = S_FINISH;
        end
        if (chk_vld_r) begin
          if (func_r == FUNC_INSERT) begin
            if (e_dup) begin
              dup_nxt = 1'b1;
            end
            if (!chk_vbit_r && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = chk_idx_r;
            end
          end else if (e_match && (!best_found_r || rd_entry.length > best_len_r)) begin
            best_found_nxt = 1'b1;
            best_len_nxt   = rd_entry.length;
            best_nh_nxt    = rd_entry.gateway;
            best_port_nxt  = rd_entry.port;
          end
        end
      end
      S_FINISH: begin
        if (finish_go) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_nh_nxt    = '0;
          out_port_nxt  = '0;
          if (func_r == FUNC_INSERT) begin
            if (dup_r) begin
              out_status_nxt = ST_DUPLICATE;
            end else if (free_found_r) begin
              out_status_nxt          = ST_INSERTED;
              valid_nxt[free_idx_r]   = 1'b1;
            end else begin
              out_status_nxt = ST_FULL;
            end
          end else if (best_found_r) begin
            out_hit_nxt    = 1'b1;
            out_nh_nxt     = best_nh_r;
            out_port_nxt   = best_port_r;
            out_status_nxt = ST_FOUND;
          end else begin
            out_status_nxt = ST_NO_ROUTE;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_vbit_r   <= chk_vbit_nxt;
    chk_idx_r    <= chk_idx_nxt;
    func_r       <= func_nxt;
    addr_r       <= addr_nxt;
    len_r        <= len_nxt;
    nh_r         <= nh_nxt;
    port_r       <= port_nxt;
    dup_r        <= dup_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    best_found_r <= best_found_nxt;
    best_len_r   <= best_len_nxt;
    best_nh_r    <= best_nh_nxt;
    best_port_r  <= best_port_nxt;
    out_hit_r    <= out_hit_nxt;
    out_nh_r     <= out_nh_nxt;
    out_port_r   <= out_port_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_route_next_hop = out_nh_r;
  assign out_route_port     = out_port_r;
  assign out_status         = out_status_r;

  `LPRL_ASSERT_NXT(a_accept_starts_walk, in_acc, (state_r == S_SCAN) && (cnt_r == '0), "accepted transaction did not start a table walk")
  `LPRL_ASSERT_IMP(a_write_free_entry, ram_we, !valid_r[free_idx_r], "insert overwrites a valid entry")
  `LPRL_ASSERT_IMP(a_cnt_in_range, state_r == S_SCAN, cnt_r <= CNT_W'(ROUTE_ENTRIES), "walk counter out of range")
  `LPRL_ASSERT_IMP(a_hit_status, out_valid_r && out_hit_r, out_status_r == ST_FOUND, "hit without found status")

endmodule
